### rtl/core/rhh_pkg.sv
package rhh_pkg;

  // Divider geometry. Both divisions share one shape: a 22-bit dividend, a
  // 9-bit divisor and 13 quotient bits, one quotient bit per pipeline stage.
  localparam int DIV_QW = 13;
  localparam int DIV_DW = 9;
  localparam int DIV_NW = DIV_DW + DIV_QW;

  localparam int HUE_W   = 15;
  localparam int LEVEL_W = 9;

  // Twice the 60 degree sector in 1/64 degree, and twice the 255 scale.
  localparam logic [12:0] HUE_SECTOR2 = 13'd7680;
  localparam logic [8:0]  SAT_SCALE2  = 9'd510;

  // A full turn in 1/64 degree.
  localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

  // Hue offsets per maximum channel, already reduced modulo a full turn and
  // with the one-sector bias of the non-negative numerator taken out.
  localparam logic [HUE_W-1:0] HUE_BASE_RED   = 15'd19200;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 15'd11520;

  // Register address decode: bit 2 of the byte address selects the register.
  localparam logic REG_OUTPUT_MODE = 1'b0;

  localparam logic MODE_HSV = 1'b0;
  localparam logic MODE_HSL = 1'b1;

  // Fields that ride alongside the divisions.
  typedef struct packed {
    logic [HUE_W-1:0]   base;
    logic               gray;
    logic [LEVEL_W-1:0] level;
    logic               clamp;
  } side_t;

endpackage

### rtl/core/rhh_div_pipe.sv
module rhh_div_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rhh_pkg::DIV_NW-1:0]   hue_num,
  input  logic [rhh_pkg::DIV_DW-1:0]   hue_den,
  input  logic [rhh_pkg::DIV_NW-1:0]   sat_num,
  input  logic [rhh_pkg::DIV_DW-1:0]   sat_den,
  input  rhh_pkg::side_t               side_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rhh_pkg::DIV_QW-1:0]   hue_quo,
  output logic [rhh_pkg::DIV_QW-1:0]   sat_quo,
  output rhh_pkg::side_t               side_out
);
  import rhh_pkg::*;

  // One restoring division step. The upper DW bits hold the partial
  // remainder, the lower bits hold the unused dividend bits and then the
  // quotient bits as they are produced.
  function automatic logic [DIV_NW-1:0] div_step(input logic [DIV_NW-1:0] rq,
                                                 input logic [DIV_DW-1:0] d);
    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    trial = rq[DIV_NW-1:DIV_QW-1];
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {diff[DIV_DW-1:0], rq[DIV_QW-2:0], 1'b1};
    end else begin
      div_step = {trial[DIV_DW-1:0], rq[DIV_QW-2:0], 1'b0};
    end
  endfunction

  logic [DIV_NW-1:0] rq_h  [DIV_QW];
  logic [DIV_NW-1:0] rq_s  [DIV_QW];
  logic [DIV_DW-1:0] dh    [DIV_QW];
  logic [DIV_DW-1:0] ds    [DIV_QW];
  side_t             side  [DIV_QW];
  logic              v     [DIV_QW];
  logic              en    [DIV_QW];

  genvar k;
  generate
    for (k = 0; k < DIV_QW; k++) begin : g_stage
      if (k == DIV_QW - 1) begin : g_last
        assign en[k] = !v[k] || !out_stall;
      end else begin : g_mid
        assign en[k] = !v[k] || en[k+1];
      end

      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (rst) begin
            v[k] <= 1'b0;
          end else if (en[k]) begin
            v[k] <= in_valid;
          end
        end
        always_ff @(posedge clk) begin
          if (en[k]) begin
            rq_h[k] <= div_step(hue_num, hue_den);
            rq_s[k] <= div_step(sat_num, sat_den);
            dh[k]   <= hue_den;
            ds[k]   <= sat_den;
            side[k] <= side_in;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (rst) begin
            v[k] <= 1'b0;
          end else if (en[k]) begin
            v[k] <= v[k-1];
          end
        end
        always_ff @(posedge clk) begin
          if (en[k]) begin
            rq_h[k] <= div_step(rq_h[k-1], dh[k-1]);
            rq_s[k] <= div_step(rq_s[k-1], ds[k-1]);
            dh[k]   <= dh[k-1];
            ds[k]   <= ds[k-1];
            side[k] <= side[k-1];
          end
        end
      end
    end
  endgenerate

  assign in_stall  = !en[0];
  assign out_valid = v[DIV_QW-1];
  assign hue_quo   = rq_h[DIV_QW-1][DIV_QW-1:0];
  assign sat_quo   = rq_s[DIV_QW-1][DIV_QW-1:0];
  assign side_out  = side[DIV_QW-1];

endmodule

### rtl/core/rgb_to_hsv_hsl.sv
// Channel   Direction  Handshake                 Word
// --------  ---------  ------------------------  --------------------------------
// pixel in  input      in_valid / in_stall       red, green, blue, clamped_in
// result    output     out_valid / out_stall     hue, saturation, level, clamped_out
// config    input      APB (psel, penable, ...)  output_mode at byte address 0
//
// One pixel can be accepted every cycle while in_stall is low. The depth is set
// by the two dividers, which produce one quotient bit per stage over 13 stages.
// rst is synchronous and clears all valid bits and output_mode; data registers
// are not reset. A stall from the output side fills empty stages first, so
// in_stall rises only once every stage holds a word.
module rgb_to_hsv_hsl (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  logic                        clamped_in,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rhh_pkg::HUE_W-1:0]   hue,
  output logic [7:0]                  saturation,
  output logic [rhh_pkg::LEVEL_W-1:0] level,
  output logic                        clamped_out
);
  import rhh_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration register. Only bit 0 of the written data is kept; writes
  // to any other register address are dropped.
  // ---------------------------------------------------------------------
  logic output_mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= MODE_HSV;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OUTPUT_MODE)) begin
      output_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_OUTPUT_MODE) begin
      prdata = {31'd0, output_mode};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: maximum, minimum and their spread, the channel that owns the
  // maximum (red wins ties over green, green over blue), and the numerator
  // offset x = diff + delta, which always lies in 0 to 2*delta.
  // ---------------------------------------------------------------------
  logic [7:0]         mx, mn, delta;
  logic [8:0]         sum;
  logic [8:0]         x;
  logic [7:0]         den;
  logic [HUE_W-1:0]   base;
  logic [LEVEL_W-1:0] lvl;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};

    if (red >= green && red >= blue) begin
      x    = 9'({1'b0, green} + {1'b0, delta} - {1'b0, blue});
      base = HUE_BASE_RED;
    end else if (green >= blue) begin
      x    = 9'({1'b0, blue} + {1'b0, delta} - {1'b0, red});
      base = HUE_BASE_GREEN;
    end else begin
      x    = 9'({1'b0, red} + {1'b0, delta} - {1'b0, green});
      base = HUE_BASE_BLUE;
    end

    // Saturation denominator: max for HSV, and for HSL the distance of the
    // lightness sum from the nearer end of its range.
    if (output_mode == MODE_HSV) begin
      den = mx;
      lvl = {mx, 1'b0};
    end else begin
      den = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
      lvl = sum;
    end
  end

  logic        s1_valid, s1_en;
  logic [8:0]  s1_x;
  logic [7:0]  s1_delta, s1_den;
  side_t       s1_side;

  logic        s2_valid, s2_en;
  logic        div_in_stall;

  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_x          <= x;
      s1_delta      <= delta;
      s1_den        <= den;
      s1_side.base  <= base;
      s1_side.gray  <= (delta == 8'd0);
      s1_side.level <= lvl;
      s1_side.clamp <= clamped_in;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: build the rounded-division operands. Rounding to nearest with
  // halves up is floor((2*n + d) / (2*d)), so both numerators carry the
  // divisor once and both divisors are doubled.
  //   hue:        (7680*x + delta)      / (2*delta)
  //   saturation: (510*delta + den)     / (2*den)
  // ---------------------------------------------------------------------
  logic [DIV_NW-1:0] s2_hue_num, s2_sat_num;
  logic [DIV_DW-1:0] s2_hue_den, s2_sat_den;
  side_t             s2_side;

  assign s2_en = !s2_valid || !div_in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_hue_num <= DIV_NW'(s1_x) * DIV_NW'(HUE_SECTOR2) + DIV_NW'(s1_delta);
      s2_sat_num <= DIV_NW'(s1_delta) * DIV_NW'(SAT_SCALE2) + DIV_NW'(s1_den);
      s2_hue_den <= {s1_delta, 1'b0};
      s2_sat_den <= {s1_den, 1'b0};
      s2_side    <= s1_side;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3 to 15: both divisions, one quotient bit per stage. A gray
  // pixel divides by zero here; its quotients are discarded below.
  // ---------------------------------------------------------------------
  logic              div_out_valid, div_out_stall;
  logic [DIV_QW-1:0] hue_quo, sat_quo;
  side_t             div_side;

  rhh_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_stall  (div_in_stall),
    .hue_num   (s2_hue_num),
    .hue_den   (s2_hue_den),
    .sat_num   (s2_sat_num),
    .sat_den   (s2_sat_den),
    .side_in   (s2_side),
    .out_valid (div_out_valid),
    .out_stall (div_out_stall),
    .hue_quo   (hue_quo),
    .sat_quo   (sat_quo),
    .side_out  (div_side)
  );

  // ---------------------------------------------------------------------
  // Stage 16: add the sector offset, wrap once into a full turn, and force
  // hue and saturation to zero for gray pixels. This is the output register.
  // ---------------------------------------------------------------------
  logic             out_en;
  logic [HUE_W-1:0] hue_sum, hue_wrap;

  assign out_en        = !out_valid || !out_stall;
  assign div_out_stall = !out_en;

  always_comb begin
    hue_sum  = div_side.base + HUE_W'(hue_quo);
    hue_wrap = (hue_sum >= HUE_FULL) ? (hue_sum - HUE_FULL) : hue_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      hue         <= div_side.gray ? '0 : hue_wrap;
      saturation  <= div_side.gray ? 8'd0 : sat_quo[7:0];
      level       <= div_side.level;
      clamped_out <= div_side.clamp;
    end
  end

endmodule
